>>> rtl/upi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upi_pkg
// Shared widths, sequencer states, CORDIC arc table and rounding helpers
// for the unicycle pose integrator.
// ----------------------------------------------------------------------------
package upi_pkg;

	localparam int SPD_W   = 16;
	localparam int TS_W    = 16;
	localparam int POS_W   = 32;
	localparam int HEAD_W  = 16;
	localparam int CS_W    = 16;
	localparam int DIST_W  = 33;
	localparam int MA_W    = 34;
	localparam int MB_W    = 17;
	localparam int MP_W    = MA_W + MB_W;
	localparam int CX_W    = 34;
	localparam int CZ_W    = 33;
	localparam int STEPS   = 16;
	localparam int ITER_W  = 4;
	localparam int SUM_W   = 37;
	localparam int DX_W    = MP_W - 15;
	localparam int IN_W    = 32;
	localparam int OUT_W   = 80;

	localparam logic [TS_W-1:0]        TS_RESET    = 16'd256;
	localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HEAD,
		ST_DIST,
		ST_LOAD,
		ST_ROT,
		ST_MULX,
		ST_MULY,
		ST_ACCY,
		ST_OUT
	} upi_state_t;

	typedef struct packed {
		logic                   done;
		logic signed [CS_W-1:0] cos_v;
		logic signed [CS_W-1:0] sin_v;
	} upi_cordic_res_t;

	// arc tangent of 2^-i in 2^-32 turn units
	function automatic logic [CZ_W-1:0] arc_angle(input logic [ITER_W-1:0] i);
		logic [CZ_W-1:0] a;
		unique case (i)
			4'd0:  a = 33'h020000000;
			4'd1:  a = 33'h012E4051E;
			4'd2:  a = 33'h009FB385B;
			4'd3:  a = 33'h0051111D4;
			4'd4:  a = 33'h0028B0D43;
			4'd5:  a = 33'h00145D7E1;
			4'd6:  a = 33'h000A2F61E;
			4'd7:  a = 33'h000517C55;
			4'd8:  a = 33'h00028BE53;
			4'd9:  a = 33'h000145F2F;
			4'd10: a = 33'h0000A2F98;
			4'd11: a = 33'h0000517CC;
			4'd12: a = 33'h000028BE6;
			4'd13: a = 33'h0000145F3;
			4'd14: a = 33'h00000A2FA;
			4'd15: a = 33'h00000517D;
			default: a = '0;
		endcase
		return a;
	endfunction

	// Q1.30 to Q1.15, round half up, clamp to +-32767
	function automatic logic signed [CS_W-1:0] to_q15(input logic signed [CX_W-1:0] v);
		logic signed [CX_W:0]    sum;
		logic signed [CX_W-15:0] r;
		logic signed [CS_W-1:0]  q;
		sum = {v[CX_W-1], v} + (CX_W+1)'(16384);
		r   = sum[CX_W:15];
		if (r > 20'sd32767) begin
			q = 16'sd32767;
		end else if (r < -20'sd32767) begin
			q = -16'sd32767;
		end else begin
			q = r[CS_W-1:0];
		end
		return q;
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
		logic signed [POS_W-1:0] p;
		if (v > 37'sd2147483647) begin
			p = 32'sh7FFFFFFF;
		end else if (v < -37'sd2147483648) begin
			p = 32'sh80000000;
		end else begin
			p = v[POS_W-1:0];
		end
		return p;
	endfunction

endpackage
`default_nettype wire

>>> rtl/upi_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upi_mul
// Shared signed multiplier with a registered product, used for the heading
// increment, the distance and both position steps.
// ----------------------------------------------------------------------------
module upi_mul (
	input  wire logic                             clk,
	input  wire logic signed [upi_pkg::MA_W-1:0]  a,
	input  wire logic signed [upi_pkg::MB_W-1:0]  b,
	output logic signed [upi_pkg::MP_W-1:0]       p_q
);

	always_ff @(posedge clk) begin
		p_q <= upi_pkg::MP_W'(a) * upi_pkg::MP_W'(b);
	end

endmodule
`default_nettype wire

>>> rtl/upi_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upi_cordic
// Iterative rotation-mode CORDIC: one shift-add step per cycle over sixteen
// steps, then rounding of cosine and sine to Q1.15.
// ----------------------------------------------------------------------------
module upi_cordic (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [upi_pkg::HEAD_W-1:0]         angle,
	output upi_pkg::upi_cordic_res_t                res
);

	logic signed [upi_pkg::CX_W-1:0]  x_q, y_q, x_nx, y_nx, xs, ys;
	logic signed [upi_pkg::CZ_W-1:0]  z_q, z_nx, z_in, z_fold, arc;
	logic [upi_pkg::ITER_W-1:0]       iter_q;
	logic                             run_q, fin_q, done_q, flip_q, flip_in;
	logic signed [upi_pkg::CS_W-1:0]  cos_q, sin_q, cos_r, sin_r;

	// fold into -1/4..1/4 turn
	always_comb begin
		z_in    = {angle[upi_pkg::HEAD_W-1], angle, 16'h0000};
		flip_in = 1'b0;
		z_fold  = z_in;
		if (z_in > 33'sd1073741824) begin
			z_fold  = z_in - 33'sd2147483648;
			flip_in = 1'b1;
		end else if (z_in < -33'sd1073741824) begin
			z_fold  = z_in + 33'sd2147483648;
			flip_in = 1'b1;
		end
	end

	always_comb begin
		xs  = x_q >>> iter_q;
		ys  = y_q >>> iter_q;
		arc = signed'(upi_pkg::arc_angle(iter_q));
		if (!z_q[upi_pkg::CZ_W-1]) begin
			x_nx = x_q - ys;
			y_nx = y_q + xs;
			z_nx = z_q - arc;
		end else begin
			x_nx = x_q + ys;
			y_nx = y_q - xs;
			z_nx = z_q + arc;
		end
	end

	always_comb begin
		cos_r = upi_pkg::to_q15(x_q);
		sin_r = upi_pkg::to_q15(y_q);
		if (flip_q) begin
			cos_r = -cos_r;
			sin_r = -sin_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= run_q && (iter_q == upi_pkg::ITER_W'(upi_pkg::STEPS - 1));
			if (start) begin
				run_q  <= 1'b1;
				iter_q <= '0;
			end else if (run_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == upi_pkg::ITER_W'(upi_pkg::STEPS - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= upi_pkg::CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= z_fold;
			flip_q <= flip_in;
		end else if (run_q) begin
			x_q <= x_nx;
			y_q <= y_nx;
			z_q <= z_nx;
		end
		if (fin_q) begin
			cos_q <= cos_r;
			sin_q <= sin_r;
		end
	end

	assign res.done  = done_q;
	assign res.cos_v = cos_q;
	assign res.sin_v = sin_q;

endmodule
`default_nettype wire

>>> rtl/unicycle_pose_integrator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unicycle_pose_integrator_top
// Dead-reckoning pose integrator: heading advance, CORDIC cosine and sine,
// saturating Q16.16 position update, all under one small sequencer.
//
//   channel  dir  signals                         contents
//   s        in   s_tvalid s_tready s_tdata[31:0] one speed tick
//   m        out  m_tvalid m_tready m_tdata[79:0] updated pose
//   cfg      in   cfg_valid cfg_ready cfg_data    integration step
//
// A tick is taken only in the idle state, so a new item waits until the last
// has passed the output state; the result is registered there. The 16 CORDIC
// iterations and four passes through the shared multiplier lie on this path.
// Reset clears the pose to zero and the step to 1.0.
// A result waiting on m_tready does not stop the next tick from being taken;
// a second finished result waits in its last state until the first is taken.
// ----------------------------------------------------------------------------
module unicycle_pose_integrator_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [upi_pkg::IN_W-1:0]      s_tdata,   // linear_speed, angular_speed
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [upi_pkg::OUT_W-1:0]          m_tdata,   // position_x, position_y, heading
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [upi_pkg::TS_W-1:0]      cfg_data
);

	upi_pkg::upi_state_t state_q, state_nx;

	logic [upi_pkg::TS_W-1:0]          ts_q;
	logic signed [upi_pkg::SPD_W-1:0]  lin_q, ang_q;
	logic signed [upi_pkg::DIST_W-1:0] dist_q;
	logic [upi_pkg::HEAD_W-1:0]        angle_q;
	logic signed [upi_pkg::POS_W-1:0]  pos_x_q, pos_y_q;
	logic                              m_tvalid_q;
	logic [upi_pkg::OUT_W-1:0]         m_tdata_q;

	logic signed [upi_pkg::MA_W-1:0]   mul_a;
	logic signed [upi_pkg::MB_W-1:0]   mul_b;
	logic signed [upi_pkg::MP_W-1:0]   prod_q;
	logic signed [upi_pkg::MP_W-1:0]   prod_rnd;
	logic signed [upi_pkg::DX_W-1:0]   step_v;
	logic [23:0]                       turn_v;
	logic                              cordic_start, ang_upd, dist_ld, x_upd, y_upd, out_ld;
	logic                              out_free;
	upi_pkg::upi_cordic_res_t          cres;

	upi_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	upi_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.angle  (angle_q),
		.res    (cres)
	);

	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			upi_pkg::ST_IDLE: if (s_tvalid) state_nx = upi_pkg::ST_HEAD;
			upi_pkg::ST_HEAD: state_nx = upi_pkg::ST_DIST;
			upi_pkg::ST_DIST: state_nx = upi_pkg::ST_LOAD;
			upi_pkg::ST_LOAD: state_nx = upi_pkg::ST_ROT;
			upi_pkg::ST_ROT:  if (cres.done) state_nx = upi_pkg::ST_MULX;
			upi_pkg::ST_MULX: state_nx = upi_pkg::ST_MULY;
			upi_pkg::ST_MULY: state_nx = upi_pkg::ST_ACCY;
			upi_pkg::ST_ACCY: state_nx = upi_pkg::ST_OUT;
			upi_pkg::ST_OUT:  if (out_free) state_nx = upi_pkg::ST_IDLE;
			default:          state_nx = upi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cordic_start = 1'b0;
		ang_upd      = 1'b0;
		dist_ld      = 1'b0;
		x_upd        = 1'b0;
		y_upd        = 1'b0;
		out_ld       = 1'b0;
		mul_a        = upi_pkg::MA_W'(dist_q);
		mul_b        = upi_pkg::MB_W'(cres.cos_v);
		unique case (state_q)
			upi_pkg::ST_IDLE: s_tready = 1'b1;
			upi_pkg::ST_HEAD: begin
				mul_a = upi_pkg::MA_W'(ang_q);
				mul_b = signed'({1'b0, ts_q});
			end
			upi_pkg::ST_DIST: begin
				mul_a   = upi_pkg::MA_W'(lin_q);
				mul_b   = signed'({1'b0, ts_q});
				ang_upd = 1'b1;
			end
			upi_pkg::ST_LOAD: begin
				cordic_start = 1'b1;
				dist_ld      = 1'b1;
			end
			upi_pkg::ST_ROT:  ;
			upi_pkg::ST_MULX: ;
			upi_pkg::ST_MULY: begin
				mul_b = upi_pkg::MB_W'(cres.sin_v);
				x_upd = 1'b1;
			end
			upi_pkg::ST_ACCY: y_upd = 1'b1;
			upi_pkg::ST_OUT:  out_ld = out_free;
			default:          ;
		endcase
	end

	// heading increment rounded half up, position step rounded half up
	assign turn_v   = prod_q[23:0] + 24'd128;
	assign prod_rnd = prod_q + upi_pkg::MP_W'(16384);
	assign step_v   = prod_rnd[upi_pkg::MP_W-1:15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= upi_pkg::ST_IDLE;
			ts_q       <= upi_pkg::TS_RESET;
			angle_q    <= '0;
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				ts_q <= cfg_data;
			end
			if (ang_upd) begin
				angle_q <= angle_q + turn_v[23:8];
			end
			if (x_upd) begin
				pos_x_q <= upi_pkg::sat_pos(upi_pkg::SUM_W'(pos_x_q) + upi_pkg::SUM_W'(step_v));
			end
			if (y_upd) begin
				pos_y_q <= upi_pkg::sat_pos(upi_pkg::SUM_W'(pos_y_q) + upi_pkg::SUM_W'(step_v));
			end
			if (out_ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			lin_q <= s_tdata[15:0];
			ang_q <= s_tdata[31:16];
		end
		if (dist_ld) begin
			dist_q <= prod_q[upi_pkg::DIST_W-1:0];
		end
		if (out_ld) begin
			m_tdata_q <= {angle_q, pos_y_q, pos_x_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_done_in_rot: assert property (@(posedge clk) disable iff (!arst_n)
		cres.done |-> state_q == upi_pkg::ST_ROT)
		else $error("cordic done outside rotation wait");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second transfer taken while busy");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == upi_pkg::ST_OUT))
		else $error("result raised outside output state");

	a_heading_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != upi_pkg::ST_DIST |=> $stable(angle_q))
		else $error("heading changed outside its update");

endmodule
`default_nettype wire

>>> verif/pose_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pose_checker
// Watches the tick, pose and step channels of the pose integrator. Every
// accepted tick advances a private copy of the heading and position: it
// rounds the heading increment, runs a 16-step CORDIC for the cosine and
// sine, and applies a saturating Q16.16 update. The predicted pose is then
// queued. Each pose transfer is compared field by field with the oldest
// queued pose. The count of mismatches and the number of poses still due
// are handed to the test top.
// ----------------------------------------------------------------------------
module pose_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	input  wire logic                          s_tready,
	input  wire logic [upi_pkg::IN_W-1:0]      s_tdata,   // linear_speed, angular_speed
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic [upi_pkg::OUT_W-1:0]     m_tdata,   // position_x, position_y, heading
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [upi_pkg::TS_W-1:0]      cfg_data,
	output int                                 mismatches,
	output int                                 outstanding
);

	localparam longint QUARTER_TURN = 64'sd1073741824;
	localparam longint HALF_TURN    = 64'sd2147483648;
	localparam longint UNIT_GAIN    = 64'sd652032874;

	typedef struct packed {
		logic [upi_pkg::HEAD_W-1:0]       heading;
		logic signed [upi_pkg::POS_W-1:0] y;
		logic signed [upi_pkg::POS_W-1:0] x;
	} pose_t;

	// arc tangent of 2^-i in 2^-32 turn
	longint arc_table [0:15] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
		64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
		64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
	};

	logic [upi_pkg::TS_W-1:0]         step_size;
	logic signed [upi_pkg::POS_W-1:0] est_x;
	logic signed [upi_pkg::POS_W-1:0] est_y;
	logic [upi_pkg::HEAD_W-1:0]       est_heading;
	pose_t                            pending_poses [$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	function automatic longint round_q15(input longint v);
		longint r;
		r = (v + 16384) >>> 15;
		if (r > 32767) begin
			r = 32767;
		end else if (r < -32767) begin
			r = -32767;
		end
		return r;
	endfunction

	function automatic logic signed [upi_pkg::POS_W-1:0] clamp32(input longint v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic void cordic_sin_cos(input logic [15:0] a, output longint c,
			output longint s);
		longint z;
		longint x;
		longint y;
		longint nx;
		bit     flip;
		z    = longint'(a) * 65536;
		x    = UNIT_GAIN;
		y    = 0;
		flip = 1'b0;
		if (z >= HALF_TURN) begin
			z = z - 2 * HALF_TURN;
		end
		// fold the back half plane onto the front one
		if (z > QUARTER_TURN) begin
			z    = z - HALF_TURN;
			flip = 1'b1;
		end else if (z < -QUARTER_TURN) begin
			z    = z + HALF_TURN;
			flip = 1'b1;
		end
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z  = z - arc_table[i];
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z  = z + arc_table[i];
			end
			x = nx;
		end
		c = round_q15(x);
		s = round_q15(y);
		if (flip) begin
			c = -c;
			s = -s;
		end
	endfunction

	function automatic pose_t advance_pose(input logic signed [15:0] lin,
			input logic signed [15:0] ang);
		longint turn;
		longint travel;
		longint c;
		longint s;
		pose_t  p;
		turn        = longint'(ang) * longint'(step_size) + 128;
		est_heading = est_heading + turn[23:8];
		cordic_sin_cos(est_heading, c, s);
		travel = longint'(lin) * longint'(step_size);
		est_x  = clamp32(longint'(est_x) + ((travel * c + 16384) >>> 15));
		est_y  = clamp32(longint'(est_y) + ((travel * s + 16384) >>> 15));
		p.x       = est_x;
		p.y       = est_y;
		p.heading = est_heading;
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		pose_t want;
		pose_t got;
		if (!arst_n) begin
			step_size   = upi_pkg::TS_RESET;
			est_x       = '0;
			est_y       = '0;
			est_heading = '0;
			pending_poses.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = pose_t'(m_tdata);
				if (pending_poses.size() == 0) begin
					$display("%0t: unexpected pose transfer x %0d y %0d heading %0d",
						$time, got.x, got.y, got.heading);
					mismatches++;
				end else begin
					want = pending_poses.pop_front();
					if (got.x !== want.x) begin
						$display("%0t: position_x expected %0d actual %0d",
							$time, want.x, got.x);
						mismatches++;
					end
					if (got.y !== want.y) begin
						$display("%0t: position_y expected %0d actual %0d",
							$time, want.y, got.y);
						mismatches++;
					end
					if (got.heading !== want.heading) begin
						$display("%0t: heading expected %0d actual %0d",
							$time, want.heading, got.heading);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				step_size = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				pending_poses.push_back(advance_pose(s_tdata[15:0], s_tdata[31:16]));
			end
		end
		outstanding = pending_poses.size();
	end

endmodule

>>> verif/unicycle_pose_integrator_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unicycle_pose_integrator_top_test
// Drives speed ticks and integration steps into the pose integrator with
// random gaps and output stalls, and lets pose_checker judge every pose.
// A short directed run covers speed extremes, quarter and half turn
// headings, heading wrap and position saturation. It is followed by random
// phases over several step sizes, the extremes among them.
// ----------------------------------------------------------------------------
module unicycle_pose_integrator_top_test;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int PHASE_TICKS  = 195;
	localparam int PHASES       = 10;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [upi_pkg::IN_W-1:0]      s_tdata;   // linear_speed, angular_speed
	logic                          m_tvalid;
	logic                          m_tready;
	logic [upi_pkg::OUT_W-1:0]     m_tdata;   // position_x, position_y, heading
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [upi_pkg::TS_W-1:0]      cfg_data;
	int                            mismatches;
	int                            outstanding;
	int                            cycle_count = 0;
	bit                            calm = 1'b0;

	always #5 clk = ~clk;

	unicycle_pose_integrator_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	pose_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("unicycle_pose_integrator_top_test NOT OK");
			$finish;
		end
	end

	// pose sink with random stall bursts
	initial begin : pose_sink
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 150 : 20))
				@(negedge clk);
		end
	end

	function automatic logic [15:0] pick_speed();
		logic [15:0] v;
		case ($urandom_range(0, 7))
			0: v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			1, 2, 3: v = 16'($urandom_range(0, 2047)) - 16'd1024;
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	// called and returns at a falling edge
	task automatic send_tick(input logic [15:0] lin, input logic [15:0] ang);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {ang, lin};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_step(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin : stimulus
		logic [15:0] step;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset step of 1.0: heading moves by angular_speed exactly
		send_tick(16'h0000, 16'h0000);
		send_tick(16'h7FFF, 16'h0000);
		send_tick(16'h8000, 16'h0000);
		send_tick(16'h0100, 16'h4000);
		send_tick(16'h0100, 16'h0001);
		send_tick(16'h0100, 16'h3FFF);
		send_tick(16'h0100, 16'h8000);
		send_tick(16'h0100, 16'hFFFF);
		send_tick(16'h0000, 16'h7FFF);
		send_tick(16'h0000, 16'h8000);
		send_tick(16'h7FFF, 16'h7FFF);
		send_tick(16'h8000, 16'h8000);
		send_tick(16'h0064, 16'h2000);
		drain();

		// largest step: drive the position into both clamps
		write_step(16'hFFFF);
		send_tick(16'h7FFF, 16'h0000);
		send_tick(16'h7FFF, 16'h0000);
		send_tick(16'h7FFF, 16'h0000);
		repeat (5) send_tick(16'h8000, 16'h0000);
		send_tick(16'h0000, 16'h0001);
		send_tick(16'h0000, 16'hFFFF);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: step = 16'h0000;
				1: step = 16'hFFFF;
				2: step = 16'h0001;
				3: step = 16'h0100;
				4: step = 16'h00FF;
				5: step = 16'h0080;
				default: step = 16'($urandom);
			endcase
			calm = (phase == PHASES - 1);
			write_step(step);
			repeat (PHASE_TICKS) send_tick(pick_speed(), pick_speed());
			drain();
		end

		repeat (40) @(negedge clk);
		if (mismatches == 0) begin
			$display("unicycle_pose_integrator_top_test OK");
		end else begin
			$display("unicycle_pose_integrator_top_test NOT OK");
		end
		$finish;
	end

endmodule
